// ===== sv/lss_pkg.sv =====
// Shared types, constants and opcode decode for the 6502 load/store/stack unit.
// No dependencies.
`default_nettype none
package lss_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int ADDR_W    = 16;
    localparam logic [7:0] STACK_PAGE = 8'h01;

    localparam logic [2:0] OP_BAD = 3'd0;
    localparam logic [2:0] OP_LDI = 3'd1;
    localparam logic [2:0] OP_LD  = 3'd2;
    localparam logic [2:0] OP_ST  = 3'd3;
    localparam logic [2:0] OP_PH  = 3'd4;
    localparam logic [2:0] OP_PL  = 3'd5;

    localparam logic [1:0] RG_A = 2'd0;
    localparam logic [1:0] RG_X = 2'd1;
    localparam logic [1:0] RG_Y = 2'd2;
    localparam logic [1:0] RG_P = 2'd3;

    localparam logic [2:0] AM_ZP  = 3'd0;
    localparam logic [2:0] AM_ZPX = 3'd1;
    localparam logic [2:0] AM_ZPY = 3'd2;
    localparam logic [2:0] AM_ABS = 3'd3;
    localparam logic [2:0] AM_ABX = 3'd4;
    localparam logic [2:0] AM_ABY = 3'd5;
    localparam logic [2:0] AM_INX = 3'd6;
    localparam logic [2:0] AM_INY = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] rg;
        logic [2:0] am;
    } dec_t;

    function automatic dec_t decode(input logic [7:0] opc);
        dec_t d;
        d.op = OP_LD;
        d.rg = RG_A;
        d.am = AM_ZP;
        case (opc)
            8'hA9: begin d.op = OP_LDI; d.rg = RG_A; end
            8'hA2: begin d.op = OP_LDI; d.rg = RG_X; end
            8'hA0: begin d.op = OP_LDI; d.rg = RG_Y; end
            8'hA5: begin d.rg = RG_A; d.am = AM_ZP;  end
            8'hB5: begin d.rg = RG_A; d.am = AM_ZPX; end
            8'hAD: begin d.rg = RG_A; d.am = AM_ABS; end
            8'hBD: begin d.rg = RG_A; d.am = AM_ABX; end
            8'hB9: begin d.rg = RG_A; d.am = AM_ABY; end
            8'hA1: begin d.rg = RG_A; d.am = AM_INX; end
            8'hB1: begin d.rg = RG_A; d.am = AM_INY; end
            8'hA6: begin d.rg = RG_X; d.am = AM_ZP;  end
            8'hB6: begin d.rg = RG_X; d.am = AM_ZPY; end
            8'hAE: begin d.rg = RG_X; d.am = AM_ABS; end
            8'hBE: begin d.rg = RG_X; d.am = AM_ABY; end
            8'hA4: begin d.rg = RG_Y; d.am = AM_ZP;  end
            8'hB4: begin d.rg = RG_Y; d.am = AM_ZPX; end
            8'hAC: begin d.rg = RG_Y; d.am = AM_ABS; end
            8'hBC: begin d.rg = RG_Y; d.am = AM_ABX; end
            8'h85: begin d.op = OP_ST; d.rg = RG_A; d.am = AM_ZP;  end
            8'h95: begin d.op = OP_ST; d.rg = RG_A; d.am = AM_ZPX; end
            8'h8D: begin d.op = OP_ST; d.rg = RG_A; d.am = AM_ABS; end
            8'h9D: begin d.op = OP_ST; d.rg = RG_A; d.am = AM_ABX; end
            8'h99: begin d.op = OP_ST; d.rg = RG_A; d.am = AM_ABY; end
            8'h81: begin d.op = OP_ST; d.rg = RG_A; d.am = AM_INX; end
            8'h91: begin d.op = OP_ST; d.rg = RG_A; d.am = AM_INY; end
            8'h86: begin d.op = OP_ST; d.rg = RG_X; d.am = AM_ZP;  end
            8'h96: begin d.op = OP_ST; d.rg = RG_X; d.am = AM_ZPY; end
            8'h8E: begin d.op = OP_ST; d.rg = RG_X; d.am = AM_ABS; end
            8'h84: begin d.op = OP_ST; d.rg = RG_Y; d.am = AM_ZP;  end
            8'h94: begin d.op = OP_ST; d.rg = RG_Y; d.am = AM_ZPX; end
            8'h8C: begin d.op = OP_ST; d.rg = RG_Y; d.am = AM_ABS; end
            8'h48: begin d.op = OP_PH; d.rg = RG_A; end
            8'h08: begin d.op = OP_PH; d.rg = RG_P; end
            8'h68: begin d.op = OP_PL; d.rg = RG_A; end
            8'h28: begin d.op = OP_PL; d.rg = RG_P; end
            default: d.op = OP_BAD;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lss_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module lss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== sv/cpu6502_load_store_stack_unit.sv =====
// Top level of the 6502 load/store/stack unit: sequencer, register file, memory.
// Depends on lss_pkg and lss_ram.
//
// Usage: one request on s_axis (tdata = opcode, operand low, operand high)
// executes one LDA/LDX/LDY/STA/STX/STY/PHA/PHP/PLA/PLP instruction and gives
// one result on m_axis with the bus access and the registers afterwards.
// Steps per item: immediate loads, bad opcodes, direct stores and pushes go
// from ST_IDLE to ST_OUT; direct loads and pulls pass ST_DONE; indirect
// stores pass ST_PLO and ST_PHI, and indirect loads ST_PLO, ST_PHI and ST_DONE
// (two pointer-byte reads, then the data access, each through the single
// memory port with registered read). The result is offered in ST_OUT and the
// next request is taken only back in ST_IDLE. One item is worked on at a time.
// Reset: registers clear to zero, then a clearing pass writes zero to all
// 65536 memory bytes, one per cycle, so s_axis_tready stays low after rst_n
// rises until the pass is over.
// Stall: the result waits in its output register while m_axis_tready is low;
// no new request is accepted until it is taken.
`default_nettype none
module cpu6502_load_store_stack_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] opcode, [15:8] operand_low, [23:16] operand_high
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] bus_address, [23:16] bus_data, [24] bus_write, [25] has_access,
    // [33:26] acc_out, [41:34] x_out, [49:42] y_out, [57:50] sp_out,
    // [65:58] status_out, [66] bad_opcode, [71:67] zero
    output logic [71:0]      m_axis_tdata
);
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_PLO  = 3'd2;
    localparam logic [2:0] ST_PHI  = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [15:0] clr_reg;
    logic [7:0]  a_reg, x_reg, y_reg, sp_reg, p_reg;
    lss_pkg::dec_t dec_reg;
    logic [7:0]  plo_reg, ptr_reg;
    logic [15:0] addr_reg;
    logic [71:0] out_reg;
    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata, mem_rdata;

    lss_ram #(.WIDTH(8), .DEPTH(lss_pkg::MEM_DEPTH)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );

    lss_pkg::dec_t in_dec;
    logic [7:0]  in_lo, in_hi, src_val, ld_val, p_nz;
    logic [15:0] dir_addr, ind_addr;
    logic        acc_ok;

    assign in_dec = lss_pkg::decode(s_axis_tdata[7:0]);
    assign in_lo  = s_axis_tdata[15:8];
    assign in_hi  = s_axis_tdata[23:16];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;
    assign acc_ok = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        case (in_dec.am)
            lss_pkg::AM_ZP:  dir_addr = {8'h00, in_lo};
            lss_pkg::AM_ZPX: dir_addr = {8'h00, in_lo + x_reg};
            lss_pkg::AM_ZPY: dir_addr = {8'h00, in_lo + y_reg};
            lss_pkg::AM_ABS: dir_addr = {in_hi, in_lo};
            lss_pkg::AM_ABX: dir_addr = {in_hi, in_lo} + {8'h00, x_reg};
            lss_pkg::AM_ABY: dir_addr = {in_hi, in_lo} + {8'h00, y_reg};
            default:         dir_addr = '0;
        endcase
        case (in_dec.rg)
            lss_pkg::RG_X: src_val = x_reg;
            lss_pkg::RG_Y: src_val = y_reg;
            lss_pkg::RG_P: src_val = p_reg;
            default:       src_val = a_reg;
        endcase
    end

    // pointer word for indirect modes; Y applies only to (ind),Y
    assign ind_addr = {mem_rdata, plo_reg} +
                      ((dec_reg.am == lss_pkg::AM_INY) ? {8'h00, y_reg} : 16'h0000);
    assign ld_val = mem_rdata;
    assign p_nz = {ld_val[7], p_reg[6:2], (ld_val == 8'h00), p_reg[0]};

    function automatic logic [71:0] pack(
        input logic [15:0] ad, input logic [7:0] d, input logic w, input logic ac,
        input logic [7:0] a, input logic [7:0] x, input logic [7:0] y,
        input logic [7:0] s, input logic [7:0] p, input logic b);
        return {5'b0, b, p, s, y, x, a, ac, w, d, ad};
    endfunction

    // memory port mux and next-state logic
    always_comb
    begin
        mem_we = 1'b0;
        mem_addr = '0;
        mem_wdata = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
            begin
                mem_we = 1'b1;
                mem_addr = clr_reg;
                if (clr_reg == 16'hFFFF)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (acc_ok)
                begin
                    case (in_dec.op)
                        lss_pkg::OP_LD:
                        begin
                            if (in_dec.am == lss_pkg::AM_INX)
                            begin
                                mem_addr = {8'h00, in_lo + x_reg};
                                state_next = ST_PLO;
                            end
                            else if (in_dec.am == lss_pkg::AM_INY)
                            begin
                                mem_addr = {8'h00, in_lo};
                                state_next = ST_PLO;
                            end
                            else
                            begin
                                mem_addr = dir_addr;
                                state_next = ST_DONE;
                            end
                        end
                        lss_pkg::OP_ST:
                        begin
                            if (in_dec.am == lss_pkg::AM_INX)
                            begin
                                mem_addr = {8'h00, in_lo + x_reg};
                                state_next = ST_PLO;
                            end
                            else if (in_dec.am == lss_pkg::AM_INY)
                            begin
                                mem_addr = {8'h00, in_lo};
                                state_next = ST_PLO;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                mem_addr = dir_addr;
                                mem_wdata = src_val;
                                state_next = ST_OUT;
                            end
                        end
                        lss_pkg::OP_PH:
                        begin
                            mem_we = 1'b1;
                            mem_addr = {lss_pkg::STACK_PAGE, sp_reg};
                            mem_wdata = src_val;
                            state_next = ST_OUT;
                        end
                        lss_pkg::OP_PL:
                        begin
                            mem_addr = {lss_pkg::STACK_PAGE, sp_reg + 8'd1};
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_PLO:
            begin
                mem_addr = {8'h00, ptr_reg + 8'd1};
                state_next = ST_PHI;
            end
            ST_PHI:
            begin
                mem_addr = ind_addr;
                if (dec_reg.op == lss_pkg::OP_ST)
                begin
                    mem_we = 1'b1;
                    mem_wdata = (dec_reg.rg == lss_pkg::RG_A) ? a_reg : 8'h00;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            a_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            sp_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLR)
                clr_reg <= clr_reg + 16'd1;
            if (state_reg == ST_IDLE && acc_ok)
            begin
                case (in_dec.op)
                    lss_pkg::OP_LDI:
                    begin
                        case (in_dec.rg)
                            lss_pkg::RG_X: x_reg <= in_lo;
                            lss_pkg::RG_Y: y_reg <= in_lo;
                            default:       a_reg <= in_lo;
                        endcase
                        p_reg <= {in_lo[7], p_reg[6:2], (in_lo == 8'h00), p_reg[0]};
                    end
                    lss_pkg::OP_PH: sp_reg <= sp_reg - 8'd1;
                    lss_pkg::OP_PL: sp_reg <= sp_reg + 8'd1;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE)
            begin
                case (dec_reg.rg)
                    lss_pkg::RG_X: x_reg <= ld_val;
                    lss_pkg::RG_Y: y_reg <= ld_val;
                    lss_pkg::RG_P: p_reg <= ld_val;
                    default:       a_reg <= ld_val;
                endcase
                if (dec_reg.rg != lss_pkg::RG_P)
                    p_reg <= p_nz;
            end
        end
    end

    // payload values; result assembled from post-update register values
    logic [7:0] n_a, n_x, n_y, n_sp, n_p;
    always_comb
    begin
        n_a = a_reg; n_x = x_reg; n_y = y_reg; n_sp = sp_reg; n_p = p_reg;
        if (in_dec.op == lss_pkg::OP_LDI)
        begin
            case (in_dec.rg)
                lss_pkg::RG_X: n_x = in_lo;
                lss_pkg::RG_Y: n_y = in_lo;
                default:       n_a = in_lo;
            endcase
            n_p = {in_lo[7], p_reg[6:2], (in_lo == 8'h00), p_reg[0]};
        end
        if (in_dec.op == lss_pkg::OP_PH)
            n_sp = sp_reg - 8'd1;
    end

    logic [7:0] d_a, d_x, d_y, d_p;
    always_comb
    begin
        d_a = a_reg; d_x = x_reg; d_y = y_reg; d_p = p_reg;
        case (dec_reg.rg)
            lss_pkg::RG_X: d_x = ld_val;
            lss_pkg::RG_Y: d_y = ld_val;
            lss_pkg::RG_P: d_p = ld_val;
            default:       d_a = ld_val;
        endcase
        if (dec_reg.rg != lss_pkg::RG_P)
            d_p = p_nz;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && acc_ok)
        begin
            dec_reg <= in_dec;
            ptr_reg <= (in_dec.am == lss_pkg::AM_INX) ? in_lo + x_reg : in_lo;
            addr_reg <= (in_dec.op == lss_pkg::OP_PL) ?
                        {lss_pkg::STACK_PAGE, sp_reg + 8'd1} : dir_addr;
            case (in_dec.op)
                lss_pkg::OP_LDI:
                    out_reg <= pack(16'h0000, in_lo, 1'b0, 1'b0, n_a, n_x, n_y, n_sp, n_p,
                                    1'b0);
                lss_pkg::OP_ST:
                    out_reg <= pack(dir_addr, src_val, 1'b1, 1'b1, n_a, n_x, n_y, n_sp,
                                    n_p, 1'b0);
                lss_pkg::OP_PH:
                    out_reg <= pack({lss_pkg::STACK_PAGE, sp_reg}, src_val, 1'b1, 1'b1,
                                    n_a, n_x, n_y, n_sp, n_p, 1'b0);
                lss_pkg::OP_BAD:
                    out_reg <= pack(16'h0000, 8'h00, 1'b0, 1'b0, n_a, n_x, n_y, n_sp, n_p,
                                    1'b1);
                default: ;
            endcase
        end
        if (state_reg == ST_PLO)
            plo_reg <= mem_rdata;
        if (state_reg == ST_PHI)
        begin
            addr_reg <= ind_addr;
            if (dec_reg.op == lss_pkg::OP_ST)
                out_reg <= pack(ind_addr, a_reg, 1'b1, 1'b1, a_reg, x_reg, y_reg, sp_reg,
                                p_reg, 1'b0);
        end
        if (state_reg == ST_DONE)
            out_reg <= pack(addr_reg, ld_val, 1'b0, 1'b1, d_a, d_x, d_y, sp_reg, d_p,
                            1'b0);
    end

    // a result is only offered once the clearing pass is over
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> state_reg != ST_CLR)
        else $error("result during clear");
    // a stalled result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped while stalled");
    // no request is taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while busy");
    // bad opcode never reports an access
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[66]) |-> (m_axis_tdata[25:24] == 2'b00))
        else $error("bad opcode with access");
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the 6502 load/store/stack unit: directed and random instructions,
// each result checked against a register-file and memory predictor kept here.
// Depends on lss_pkg and the cpu6502_load_store_stack_unit RTL.
`default_nettype none
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // fields from the highest bit down, matching m_axis_tdata[66:0]
    typedef struct packed {
        logic        bad_opcode;
        logic [7:0]  status_out;
        logic [7:0]  sp_out;
        logic [7:0]  y_out;
        logic [7:0]  x_out;
        logic [7:0]  acc_out;
        logic        has_access;
        logic        bus_write;
        logic [7:0]  bus_data;
        logic [15:0] bus_address;
    } cpu_result_t;

    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_N = 8'h80;
    localparam int WATCHDOG_LIMIT = 200000;

    // opcodes handled by the block
    localparam logic [7:0] OPCODES [35] = '{
        8'hA9, 8'hA2, 8'hA0, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1,
        8'hA6, 8'hB6, 8'hAE, 8'hBE, 8'hA4, 8'hB4, 8'hAC, 8'hBC, 8'h85, 8'h95,
        8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91, 8'h86, 8'h96, 8'h8E, 8'h84, 8'h94,
        8'h8C, 8'h48, 8'h08, 8'h68, 8'h28};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    cpu6502_load_store_stack_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    logic [7:0] cpu_mem [lss_pkg::MEM_DEPTH];

    cpu_result_t expected_results [$];
    int          errors = 0;
    int          sent = 0;
    int          received = 0;
    int          idle_pct = 13;
    bit          hold_off = 0;
    int          quiet_cycles = 0;
    int          mem_writes = 0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
    end

    function automatic logic [7:0] flags_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r = p & ~(FLAG_Z | FLAG_N);
        if (v == 8'h00)
            r = r | FLAG_Z;
        return r | (v & FLAG_N);
    endfunction

    function automatic logic [15:0] pointer_word(input logic [7:0] zp);
        return {cpu_mem[8'(zp + 8'd1)], cpu_mem[zp]};
    endfunction

    // execute one instruction on the predictor and return the result it gives
    function automatic cpu_result_t execute_instruction(input logic [7:0] opc,
                                                        input logic [7:0] lo,
                                                        input logic [7:0] hi);
        cpu_result_t   r;
        lss_pkg::dec_t d;
        logic [15:0]   addr;
        logic [7:0]    data;
        r = '0;
        d = lss_pkg::decode(opc);
        case (d.am)
            lss_pkg::AM_ZP:  addr = {8'h00, lo};
            lss_pkg::AM_ZPX: addr = {8'h00, 8'(lo + cpu_x)};
            lss_pkg::AM_ZPY: addr = {8'h00, 8'(lo + cpu_y)};
            lss_pkg::AM_ABS: addr = {hi, lo};
            lss_pkg::AM_ABX: addr = {hi, lo} + 16'(cpu_x);
            lss_pkg::AM_ABY: addr = {hi, lo} + 16'(cpu_y);
            lss_pkg::AM_INX: addr = pointer_word(8'(lo + cpu_x));
            default:         addr = pointer_word(lo) + 16'(cpu_y);
        endcase
        case (d.rg)
            lss_pkg::RG_X: data = cpu_x;
            lss_pkg::RG_Y: data = cpu_y;
            lss_pkg::RG_P: data = cpu_p;
            default:       data = cpu_a;
        endcase
        case (d.op)
            lss_pkg::OP_LDI, lss_pkg::OP_LD:
            begin
                if (d.op == lss_pkg::OP_LD)
                begin
                    data = cpu_mem[addr];
                    r.bus_address = addr;
                    r.has_access = 1;
                end
                else
                    data = lo;
                case (d.rg)
                    lss_pkg::RG_X: cpu_x = data;
                    lss_pkg::RG_Y: cpu_y = data;
                    default:       cpu_a = data;
                endcase
                cpu_p = flags_nz(cpu_p, data);
            end
            lss_pkg::OP_ST, lss_pkg::OP_PH:
            begin
                if (d.op == lss_pkg::OP_PH)
                begin
                    addr = {lss_pkg::STACK_PAGE, cpu_sp};
                    cpu_sp = cpu_sp - 8'd1;
                end
                cpu_mem[addr] = data;
                r.bus_address = addr;
                r.bus_write = 1;
                r.has_access = 1;
            end
            lss_pkg::OP_PL:
            begin
                cpu_sp = cpu_sp + 8'd1;
                addr = {lss_pkg::STACK_PAGE, cpu_sp};
                data = cpu_mem[addr];
                if (d.rg == lss_pkg::RG_P)
                    cpu_p = data;
                else
                begin
                    cpu_a = data;
                    cpu_p = flags_nz(cpu_p, data);
                end
                r.bus_address = addr;
                r.has_access = 1;
            end
            default:
            begin
                r.bad_opcode = 1;
                data = 8'h00;
            end
        endcase
        r.bus_data = data;
        r.acc_out = cpu_a;
        r.x_out = cpu_x;
        r.y_out = cpu_y;
        r.sp_out = cpu_sp;
        r.status_out = cpu_p;
        return r;
    endfunction

    // send one request, idling at random before it; tvalid stays up after
    // acceptance until the next call or the end of the run drops it
    task automatic send_instruction(input logic [7:0] opc, input logic [7:0] lo,
                                    input logic [7:0] hi);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {hi, lo, opc};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(execute_instruction(opc, lo, hi));
        sent++;
    endtask

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 0;
        else if (hold_off)
            m_axis_tready <= 0;
        else
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        cpu_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = cpu_result_t'(m_axis_tdata[66:0]);
            received++;
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.bus_address !== want.bus_address)
                begin
                    $error("bus_address exp %h got %h", want.bus_address, got.bus_address);
                    errors++;
                end
                if (got.bus_data !== want.bus_data)
                begin
                    $error("bus_data exp %h got %h", want.bus_data, got.bus_data);
                    errors++;
                end
                if (got.bus_write !== want.bus_write)
                begin
                    $error("bus_write exp %b got %b", want.bus_write, got.bus_write);
                    errors++;
                end
                if (got.has_access !== want.has_access)
                begin
                    $error("has_access exp %b got %b", want.has_access, got.has_access);
                    errors++;
                end
                if (got.acc_out !== want.acc_out)
                begin
                    $error("acc_out exp %h got %h", want.acc_out, got.acc_out);
                    errors++;
                end
                if (got.x_out !== want.x_out)
                begin
                    $error("x_out exp %h got %h", want.x_out, got.x_out);
                    errors++;
                end
                if (got.y_out !== want.y_out)
                begin
                    $error("y_out exp %h got %h", want.y_out, got.y_out);
                    errors++;
                end
                if (got.sp_out !== want.sp_out)
                begin
                    $error("sp_out exp %h got %h", want.sp_out, got.sp_out);
                    errors++;
                end
                if (got.status_out !== want.status_out)
                begin
                    $error("status_out exp %h got %h", want.status_out, got.status_out);
                    errors++;
                end
                if (got.bad_opcode !== want.bad_opcode)
                begin
                    $error("bad_opcode exp %b got %b", want.bad_opcode, got.bad_opcode);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles with no accepted request or result, fail past WATCHDOG_LIMIT
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("cpu6502_load_store_stack_unit test failed");
            $finish;
        end
    end

    task automatic test_directed_opcodes();
        int i;
        // extremes of immediate values and flags
        send_instruction(8'hA9, 8'h00, 8'hFF);
        send_instruction(8'hA9, 8'hFF, 8'h00);
        send_instruction(8'hA2, 8'h80, 8'h00);
        send_instruction(8'hA0, 8'h7F, 8'h00);
        // zero-page wrap and absolute wrap
        send_instruction(8'h95, 8'hFF, 8'h00);
        send_instruction(8'h9D, 8'hFF, 8'hFF);
        send_instruction(8'hB6, 8'hFF, 8'h00);
        // pointer at 0xFF: high byte from 0x00
        send_instruction(8'h81, 8'h7F, 8'h00);
        send_instruction(8'hB1, 8'hFF, 8'h00);
        // stack wrap from SP=0, PHP/PLP raw
        send_instruction(8'h48, 8'h00, 8'h00);
        send_instruction(8'h08, 8'h00, 8'h00);
        send_instruction(8'h28, 8'h00, 8'h00);
        send_instruction(8'h68, 8'h00, 8'h00);
        send_instruction(8'hFF, 8'hAA, 8'h55);
        send_instruction(8'h00, 8'h55, 8'hAA);
        for (i = 0; i < 35; i += 4)
            send_instruction(OPCODES[i], 8'($urandom), 8'($urandom));
    endtask

    task automatic test_random_program(input int count, input bit small_pages);
        int i;
        logic [7:0] opc, hi;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 92)
                opc = OPCODES[$urandom_range(34)];
            else
                opc = 8'($urandom);
            hi = 8'($urandom);
            // keep most addresses in a few pages so loads see stored data
            if (small_pages && $urandom_range(3) != 0)
                hi = 8'($urandom_range(2));
            send_instruction(opc, 8'($urandom), hi);
        end
    endtask

    task automatic test_backpressure();
        int i;
        hold_off = 1;
        fork
            test_random_program(20, 1);
            begin
                for (i = 0; i < 300; i++)
                    @(posedge clk);
                hold_off = 0;
            end
        join
    endtask

    initial
    begin
        int drain;
        for (int k = 0; k < lss_pkg::MEM_DEPTH; k++)
            cpu_mem[k] = 8'h00;
        {cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p} = '0;
        @(posedge rst_n);
        test_directed_opcodes();
        test_random_program(600, 1);
        test_backpressure();
        idle_pct = 0;
        test_random_program(300, 1);
        idle_pct = 13;
        test_random_program(600, 0);
        s_axis_tvalid <= 0;
        drain = 0;
        while (expected_results.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        $display("Ran %0d instructions (%0d results): all opcodes, wrap cases,", sent, received);
        $display("bad opcodes, random stalls and a long output hold-off.");
        if (errors == 0 && expected_results.size() == 0)
            $display("cpu6502_load_store_stack_unit test passed");
        else
            $display("cpu6502_load_store_stack_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
